// ===== src/vnpd_pkg.sv =====
// ----------------------------------------------------------------------------
// vnpd_pkg: shared types and constants for the value noise point displacer
// Payload structs, register indexes and lattice hash constants.
// ----------------------------------------------------------------------------
package vnpd_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } t_out;

    localparam logic [1:0] REG_AMPLITUDE = 2'd0;
    localparam logic [1:0] REG_FREQUENCY = 2'd1;
    localparam logic [1:0] REG_SEED      = 2'd2;

    localparam logic [31:0] HASH_KX = 32'd374761393;
    localparam logic [31:0] HASH_KY = 32'd668265263;
    localparam logic [31:0] HASH_KZ = 32'd2147483647;
    localparam logic [31:0] HASH_KM = 32'd1274126177;

    localparam logic [30:0] AMP_RESET  = 31'd65536;
    localparam logic [23:0] FREQ_RESET = 24'd65536;

endpackage

// ===== src/vnpd_hash.sv =====
// ----------------------------------------------------------------------------
// vnpd_hash: lattice corner hash
// Two register stages: sum of seed and axis terms, then xor-shift and multiply.
// ----------------------------------------------------------------------------
module vnpd_hash
    import vnpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_seed,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic [15:0] o_corner
);

    logic [31:0] r_h;
    logic [15:0] r_corner;
    logic [31:0] w_x;
    logic [63:0] w_prod;

    assign w_x    = r_h ^ (r_h >> 13);
    assign w_prod = 64'(w_x) * 64'(HASH_KM);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h      <= i_seed + i_a + i_b + i_c;
            r_corner <= w_prod[31:16];
        end
    end

    assign o_corner = r_corner;

endmodule

// ===== src/vnpd_lerp.sv =====
// ----------------------------------------------------------------------------
// vnpd_lerp: registered linear blend of two Q0.16 values
// q = floor((a*(1-t) + b*t) / 2^FRAC_BITS).
// ----------------------------------------------------------------------------
module vnpd_lerp
    import vnpd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [15:0]          i_a,
    input  logic [15:0]          i_b,
    input  logic [FRAC_BITS:0]   i_t,
    output logic [15:0]          o_q
);

    localparam int AW = FRAC_BITS + 18;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [AW-1:0] w_acc;
    logic [15:0]   r_q;

    assign w_acc = AW'(i_a) * AW'(ONE - i_t) + AW'(i_b) * AW'(i_t);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= w_acc[FRAC_BITS+15:FRAC_BITS];
        end
    end

    assign o_q = r_q;

endmodule

// ===== src/value_noise_point_displace.sv =====
// ----------------------------------------------------------------------------
// value_noise_point_displace: moves a Q16.16 point by 3D value noise
//
// Input channel (i_in_valid / o_in_ready) takes one point per transfer; the
// output channel (o_out_valid / i_out_ready) returns the displaced point.
// Configuration writes (amplitude, frequency, seed) use i_cfg_we with
// i_cfg_idx and i_cfg_data, one cycle each; the user must make them only
// while the pipeline is empty, as the block itself does not enforce this.
// Throughput: one point per cycle when not stalled; stages run in lockstep
// with one advance enable, so 24 corner hashes and 21 blends are replicated.
// Reset (synchronous, active low) empties the pipeline and loads amplitude
// and frequency with 1.0 and seed with 0.
// When the receiver stalls the whole pipeline holds; o_in_ready drops only
// while a finished result waits, so no transfer is lost or repeated.
// ----------------------------------------------------------------------------
module value_noise_point_displace
    import vnpd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int PW = 57;
    localparam int QW = 58;
    localparam int NS = 11;
    localparam logic [QW-1:0] OFF_Y = QW'(((64'd317 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [QW-1:0] OFF_Z = QW'(((64'd473 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [31:0] K_SLOT [5] = '{HASH_KX, HASH_KX, HASH_KY, HASH_KY, HASH_KZ};

    logic [30:0] r_amp;
    logic [23:0] r_freq;
    logic [31:0] r_seed;

    logic [NS:1] r_vld;
    logic        w_en;
    t_in         r_pos [1:10];

    logic signed [PW-1:0] r_p [3];
    logic [31:0]          r_cell [5];
    logic [FRAC_BITS-1:0] r_f2 [5];
    logic [31:0]          r_mul [5];
    logic [FRAC_BITS-1:0] r_t2 [5];
    logic [FRAC_BITS-1:0] r_f3 [5];
    logic [31:0]          r_mk [5][2];
    logic [FRAC_BITS:0]   r_sm [4:8][5];
    logic [15:0]          w_corner [24];
    logic [15:0]          w_lx [12];
    logic [15:0]          w_ly [6];
    logic [15:0]          w_lz [3];
    logic signed [49:0]   r_dp [3];
    t_out                 r_out;

    assign w_en        = !r_vld[NS] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[NS];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp  <= AMP_RESET;
            r_freq <= FREQ_RESET;
            r_seed <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AMPLITUDE: r_amp  <= i_cfg_data[30:0];
                REG_FREQUENCY: r_freq <= i_cfg_data[23:0];
                REG_SEED:      r_seed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-1:1], i_in_valid};
        end
    end

    // stage 1: scale by frequency
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pos[1] <= i_in_data;
            r_p[0]   <= PW'(i_in_data.pos_x) * PW'($signed({1'b0, r_freq}));
            r_p[1]   <= PW'(i_in_data.pos_y) * PW'($signed({1'b0, r_freq}));
            r_p[2]   <= PW'(i_in_data.pos_z) * PW'($signed({1'b0, r_freq}));
            for (int i = 2; i <= 10; i++) begin
                r_pos[i] <= r_pos[i-1];
            end
        end
    end

    // stage 2: lattice cells and fractions; slots x0, x1, y0, y1, z
    logic signed [QW-1:0] w_q [5];
    always_comb begin
        w_q[0] = QW'(r_p[0]) >>> FRAC_BITS;
        w_q[2] = QW'(r_p[1]) >>> FRAC_BITS;
        w_q[4] = QW'(r_p[2]) >>> FRAC_BITS;
        w_q[1] = w_q[0] + $signed(OFF_Y);
        w_q[3] = w_q[2] + $signed(OFF_Z);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 5; i++) begin
                r_cell[i] <= w_q[i][FRAC_BITS+31:FRAC_BITS];
                r_f2[i]   <= w_q[i][FRAC_BITS-1:0];
            end
        end
    end

    // stage 3: axis hash terms, fraction squared
    logic [63:0]            w_mul [5];
    logic [2*FRAC_BITS-1:0] w_ff [5];
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            w_mul[i] = 64'(r_cell[i]) * 64'(K_SLOT[i]);
            w_ff[i]  = (2*FRAC_BITS)'(r_f2[i]) * (2*FRAC_BITS)'(r_f2[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 5; i++) begin
                r_mul[i] <= w_mul[i][31:0];
                r_t2[i]  <= w_ff[i][2*FRAC_BITS-1:FRAC_BITS];
                r_f3[i]  <= r_f2[i];
            end
        end
    end

    // stage 4: neighbor terms, smoothstep
    logic [FRAC_BITS+1:0]   w_w3 [5];
    logic [2*FRAC_BITS+1:0] w_s [5];
    logic [FRAC_BITS+1:0]   w_sr [5];
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            w_w3[i] = {2'b11, {FRAC_BITS{1'b0}}} - {1'b0, r_f3[i], 1'b0};
            w_s[i]  = (2*FRAC_BITS+2)'(r_t2[i]) * (2*FRAC_BITS+2)'(w_w3[i]);
            w_sr[i] = w_s[i][2*FRAC_BITS+1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 5; i++) begin
                r_mk[i][0] <= r_mul[i];
                r_mk[i][1] <= r_mul[i] + K_SLOT[i];
                r_sm[4][i] <= (w_sr[i] > (FRAC_BITS+2)'(ONE)) ? ONE : w_sr[i][FRAC_BITS:0];
            end
            for (int k = 5; k <= 8; k++) begin
                r_sm[k] <= r_sm[k-1];
            end
        end
    end

    // stages 5-6: corner hashes, index n*8 + dz*4 + dy*2 + dx
    for (genvar g = 0; g < 24; g++) begin : g_hash
        localparam int N  = g / 8;
        localparam int DZ = (g / 4) % 2;
        localparam int DY = (g / 2) % 2;
        localparam int DX = g % 2;
        localparam int XS = (N == 1) ? 1 : 0;
        localparam int YS = (N == 2) ? 3 : 2;
        vnpd_hash u_hash (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_seed   (r_seed),
            .i_a      (r_mk[XS][DX]),
            .i_b      (r_mk[YS][DY]),
            .i_c      (r_mk[4][DZ]),
            .o_corner (w_corner[g])
        );
    end

    // stage 7: blend along x
    for (genvar g = 0; g < 12; g++) begin : g_lx
        localparam int XS = ((g / 4) == 1) ? 1 : 0;
        vnpd_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_corner[2*g]),
            .i_b   (w_corner[2*g+1]),
            .i_t   (r_sm[6][XS]),
            .o_q   (w_lx[g])
        );
    end

    // stage 8: blend along y
    for (genvar g = 0; g < 6; g++) begin : g_ly
        localparam int YS = ((g / 2) == 2) ? 3 : 2;
        vnpd_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_lx[2*g]),
            .i_b   (w_lx[2*g+1]),
            .i_t   (r_sm[7][YS]),
            .o_q   (w_ly[g])
        );
    end

    // stage 9: blend along z
    for (genvar g = 0; g < 3; g++) begin : g_lz
        vnpd_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_ly[2*g]),
            .i_b   (w_ly[2*g+1]),
            .i_t   (r_sm[8][4]),
            .o_q   (w_lz[g])
        );
    end

    // stage 10: map to [-1,1) and scale by amplitude
    logic signed [17:0] w_m [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_m[i] = $signed({1'b0, w_lz[i], 1'b0}) - 18'sd65536;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dp[i] <= 50'(w_m[i]) * 50'($signed({1'b0, r_amp}));
            end
        end
    end

    // stage 11: add and saturate
    logic signed [31:0] w_pos [3];
    logic signed [34:0] w_sum [3];
    logic signed [31:0] w_sat [3];
    always_comb begin
        w_pos[0] = r_pos[10].pos_x;
        w_pos[1] = r_pos[10].pos_y;
        w_pos[2] = r_pos[10].pos_z;
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = 35'(w_pos[i]) + 35'($signed(r_dp[i][49:16]));
            if (w_sum[i] > 35'sd2147483647) begin
                w_sat[i] = 32'sh7FFFFFFF;
            end else if (w_sum[i] < -35'sd2147483648) begin
                w_sat[i] = 32'sh80000000;
            end else begin
                w_sat[i] = w_sum[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.out_x <= w_sat[0];
            r_out.out_y <= w_sat[1];
            r_out.out_z <= w_sat[2];
        end
    end

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[1])
        else $error("accepted point did not enter the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    a_last_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-1] && w_en) |=> o_out_valid)
        else $error("result lost before output register");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

endmodule
